// ===== sv/aps_frame_header_parser_defines.svh =====
// Assertion helpers for the APS frame header parser checker
`ifndef APS_FRAME_HEADER_PARSER_DEFINES_SVH
`define APS_FRAME_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, reset masks the check
`define APS_FHP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define APS_FHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/aps_fhp_pkg.sv =====
package aps_fhp_pkg;

    localparam int NUM_SLOTS   = 7;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] FT_DATA          = 2'h0;
    localparam logic [1:0] FT_CMD           = 2'h1;
    localparam logic [1:0] FT_ACK           = 2'h2;
    localparam logic [1:0] FT_INTERPAN      = 2'h3;
    localparam logic [2:0] DM_GROUP         = 3'h2;
    localparam logic [7:0] TRANSPORT_KEY_ID = 8'h05;
    localparam logic [7:0] SEC_HDR_BYTES    = 8'd5;
    localparam logic [7:0] TK_BODY_LEN      = 8'(1 + 16 + 1 + 8 + 8);
    localparam logic [8:0] GROUP_MIN_LEN    = 9'd7;
    localparam logic [8:0] DIRECT_MIN_LEN   = 9'd8;
    localparam logic [8:0] MIN_LEN          = 9'd2;

    typedef enum logic [3:0] {
        KIND_CMD     = 4'd0,
        KIND_KEYTYPE = 4'd1,
        KIND_KEYLO   = 4'd2,
        KIND_KEYHI   = 4'd3,
        KIND_KEYSEQ  = 4'd4,
        KIND_DSTEUI  = 4'd5,
        KIND_SRCEUI  = 4'd6,
        KIND_GROUP   = 4'd7,
        KIND_DSTEP   = 4'd8,
        KIND_CLUSTER = 4'd9,
        KIND_PROFILE = 4'd10,
        KIND_SRCEP   = 4'd11,
        KIND_COUNTER = 4'd12,
        KIND_NONE    = 4'd13
    } rec_kind_t;

    typedef enum logic [2:0] {
        MODE_SHORT,
        MODE_BAD,
        MODE_CMD,
        MODE_KEY,
        MODE_GROUP,
        MODE_DIRECT
    } frame_mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic        status;
        logic [1:0]  fr_type;
        logic [2:0]  dlv_mode;
        logic [2:0]  security_level;
        logic        ack_fmt;
        logic        ext_header;
        logic [3:0]  record_kind;
        logic [63:0] record_value;
        logic        last_record;
    } out_t;

    typedef struct packed {
        logic [7:0]                      fc;
        frame_mode_t                     mode;
        logic [NUM_SLOTS-1:0][63:0]      slot;
    } desc_t;

    function automatic logic [2:0] rec_count(input frame_mode_t mode);
        logic [2:0] n;
        unique case (mode)
            MODE_KEY:    n = 3'd7;
            MODE_GROUP:  n = 3'd4;
            MODE_DIRECT: n = 3'd5;
            default:     n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic rec_kind_t rec_kind(input frame_mode_t mode, input logic [2:0] idx);
        rec_kind_t k;
        k = KIND_NONE;
        unique case (mode)
            MODE_CMD: k = KIND_CMD;
            MODE_KEY:
            begin
                unique case (idx)
                    3'd0:    k = KIND_CMD;
                    3'd1:    k = KIND_KEYTYPE;
                    3'd2:    k = KIND_KEYLO;
                    3'd3:    k = KIND_KEYHI;
                    3'd4:    k = KIND_KEYSEQ;
                    3'd5:    k = KIND_DSTEUI;
                    default: k = KIND_SRCEUI;
                endcase
            end
            MODE_GROUP:
            begin
                unique case (idx)
                    3'd0:    k = KIND_GROUP;
                    3'd1:    k = KIND_CLUSTER;
                    3'd2:    k = KIND_SRCEP;
                    default: k = KIND_COUNTER;
                endcase
            end
            MODE_DIRECT:
            begin
                unique case (idx)
                    3'd0:    k = KIND_DSTEP;
                    3'd1:    k = KIND_CLUSTER;
                    3'd2:    k = KIND_PROFILE;
                    3'd3:    k = KIND_SRCEP;
                    default: k = KIND_COUNTER;
                endcase
            end
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== sv/aps_fhp_front.sv =====
module aps_fhp_front
    import aps_fhp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  in_t   item,
    output logic  desc_push,
    output desc_t desc
);

    logic [7:0]                 count_reg, count_next;
    logic [7:0]                 fc_reg, fc_next;
    logic [NUM_SLOTS-1:0][63:0] slot_reg, slot_next;

    logic [7:0] pos;
    logic [7:0] base;
    logic [7:0] off;
    logic [7:0] lane_full;
    logic       wr_en;
    logic [2:0] wr_slot;
    logic [2:0] wr_lane;
    logic [8:0] len;
    logic [8:0] key_min_len;
    logic [7:0] cmd_id;

    assign pos  = count_reg;
    assign base = (fc_reg[4:2] != 3'd0) ? (8'd2 + SEC_HDR_BYTES) : 8'd2;
    assign off  = pos - base;

    // byte position -> record slot and byte lane
    always_comb
    begin
        wr_en     = 1'b0;
        wr_slot   = 3'd0;
        lane_full = 8'd0;
        if (pos != 8'd0)
        begin
            unique case (fc_reg[1:0])
                FT_CMD:
                begin
                    if (pos == 8'd1)
                    begin
                        wr_en = 1'b1;
                    end
                    else if (pos >= base && off < TK_BODY_LEN)
                    begin
                        wr_en = 1'b1;
                        priority if (off == 8'd0)
                        begin
                            wr_slot = 3'd1;
                        end
                        else if (off <= 8'd8)
                        begin
                            wr_slot   = 3'd2;
                            lane_full = off - 8'd1;
                        end
                        else if (off <= 8'd16)
                        begin
                            wr_slot   = 3'd3;
                            lane_full = off - 8'd9;
                        end
                        else if (off == 8'd17)
                        begin
                            wr_slot = 3'd4;
                        end
                        else if (off <= 8'd25)
                        begin
                            wr_slot   = 3'd5;
                            lane_full = off - 8'd18;
                        end
                        else
                        begin
                            wr_slot   = 3'd6;
                            lane_full = off - 8'd26;
                        end
                    end
                end
                FT_DATA:
                begin
                    if (fc_reg[6:4] == DM_GROUP)
                    begin
                        wr_en = (pos <= 8'd6);
                        unique case (pos)
                            8'd2:    begin wr_slot = 3'd0; lane_full = 8'd1; end
                            8'd3:    wr_slot = 3'd1;
                            8'd4:    begin wr_slot = 3'd1; lane_full = 8'd1; end
                            8'd5:    wr_slot = 3'd2;
                            8'd6:    wr_slot = 3'd3;
                            default: wr_slot = 3'd0;
                        endcase
                    end
                    else
                    begin
                        wr_en = (pos <= 8'd7);
                        unique case (pos)
                            8'd2:    wr_slot = 3'd1;
                            8'd3:    begin wr_slot = 3'd1; lane_full = 8'd1; end
                            8'd4:    wr_slot = 3'd2;
                            8'd5:    begin wr_slot = 3'd2; lane_full = 8'd1; end
                            8'd6:    wr_slot = 3'd3;
                            8'd7:    wr_slot = 3'd4;
                            default: wr_slot = 3'd0;
                        endcase
                    end
                end
                default: wr_en = 1'b0;
            endcase
        end
    end

    assign wr_lane = lane_full[2:0];

    always_comb
    begin
        slot_next  = slot_reg;
        fc_next    = fc_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (pos == 8'd0)
            begin
                slot_next = '0;
                fc_next   = item.data_byte;
            end
            else if (wr_en)
            begin
                slot_next[wr_slot][{wr_lane, 3'b000} +: 8] = item.data_byte;
            end
            if (item.last_byte)
                count_next = 8'd0;
            else if (count_reg != 8'hFF)
                count_next = count_reg + 8'd1;
        end
    end

    // frame length including this beat, saturating
    assign len         = (count_reg == 8'hFF) ? 9'd255 : ({1'b0, count_reg} + 9'd1);
    assign key_min_len = {1'b0, base} + {1'b0, TK_BODY_LEN};
    assign cmd_id      = slot_next[0][7:0];

    always_comb
    begin
        desc_push = accept && item.last_byte;
        desc.slot = slot_next;
        desc.fc   = fc_reg;
        if (len < MIN_LEN)
        begin
            desc.fc   = 8'd0;
            desc.mode = MODE_SHORT;
        end
        else
        begin
            unique case (fc_reg[1:0])
                FT_CMD:
                    desc.mode = (cmd_id == TRANSPORT_KEY_ID && len >= key_min_len)
                              ? MODE_KEY : MODE_CMD;
                FT_DATA:
                begin
                    if (fc_reg[6:4] == DM_GROUP)
                        desc.mode = (len >= GROUP_MIN_LEN) ? MODE_GROUP : MODE_BAD;
                    else
                        desc.mode = (len >= DIRECT_MIN_LEN) ? MODE_DIRECT : MODE_BAD;
                end
                default: desc.mode = MODE_BAD;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 8'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        fc_reg   <= fc_next;
        slot_reg <= slot_next;
    end

endmodule

// ===== sv/aps_fhp_queue.sv =====
module aps_fhp_queue
    import aps_fhp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t wr_desc,
    output logic  full,
    output logic  valid,
    input  logic  pop,
    output desc_t rd_desc
);

    desc_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full    = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign rd_desc = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_desc;
    end

endmodule

// ===== sv/aps_fhp_back.sv =====
module aps_fhp_back
    import aps_fhp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  desc_valid,
    input  desc_t desc,
    output logic  desc_pop,
    output logic  empty,
    input  logic  pop,
    output out_t  result
);

    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_t       out_reg;
    out_t       rec;
    logic       advance;
    logic       is_err;
    logic [2:0] n_rec;

    assign advance = desc_valid && (!out_valid_reg || pop);
    assign is_err  = (desc.mode == MODE_SHORT) || (desc.mode == MODE_BAD);
    assign n_rec   = rec_count(desc.mode);

    always_comb
    begin
        rec.status         = is_err;
        rec.fr_type        = desc.fc[1:0];
        rec.dlv_mode       = desc.fc[6:4];
        rec.security_level = desc.fc[4:2];
        rec.ack_fmt        = desc.fc[1];
        rec.ext_header     = desc.fc[0];
        rec.record_kind    = rec_kind(desc.mode, idx_reg);
        rec.record_value   = is_err ? 64'd0 : desc.slot[idx_reg];
        rec.last_record    = (idx_reg == n_rec - 3'd1);
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        desc_pop       = 1'b0;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (rec.last_record)
            begin
                idx_next = 3'd0;
                desc_pop = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= rec;
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

// ===== sv/aps_frame_header_parser.sv =====
// APS frame header parser. Frame bytes go in one beat per cycle, the final
// byte marked by last_byte; the front end sorts each byte straight into its
// record field as it arrives, so no bytes need re-reading afterwards. On the
// final beat a frame descriptor enters a two-deep queue and the back end
// emits its records, one per cycle, from a registered output stage: 1 record
// for an error, short command or one-byte frame, 4 or 5 for a data frame,
// 7 for a transport-key command. Input is taken every cycle unless two
// finished frames are still waiting for the back end (full), and records are
// offered every cycle while the consumer keeps popping. The final byte's
// descriptor is queued, then its first record registered at the output.
module aps_frame_header_parser
    import aps_fhp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  in_t  item,
    output logic empty,
    input  logic pop,
    output out_t result
);

    logic  accept;
    logic  desc_push;
    desc_t front_desc;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    desc_t head_desc;

    assign full   = q_full;
    assign accept = push && !q_full;

    aps_fhp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .desc_push (desc_push),
        .desc      (front_desc)
    );

    aps_fhp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (desc_push),
        .wr_desc (front_desc),
        .full    (q_full),
        .valid   (q_valid),
        .pop     (q_pop),
        .rd_desc (head_desc)
    );

    aps_fhp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (q_valid),
        .desc       (head_desc),
        .desc_pop   (q_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ===== sv/aps_fhp_checker.sv =====
`include "aps_frame_header_parser_defines.svh"

module aps_fhp_checker
    import aps_fhp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic empty,
    input logic pop,
    input out_t result
);

    // a malformed frame yields exactly one zero-valued record
    `APS_FHP_ASSERT_NOW(a_err_single, !empty && result.status, result.last_record && result.record_kind == KIND_NONE && result.record_value == 64'd0, "error record malformed")

    // ack and interpan frames never parse
    `APS_FHP_ASSERT_NOW(a_type_err, !empty && (result.fr_type == FT_ACK || result.fr_type == FT_INTERPAN), result.status, "ack/interpan frame reported as parsed")

    // records of one frame leave without gaps
    `APS_FHP_ASSERT_NEXT(a_no_gap, pop && !empty && !result.last_record, !empty, "gap inside a frame's records")

    // transport key: key type is followed by the low key half
    `APS_FHP_ASSERT_NEXT(a_key_order, pop && !empty && result.record_kind == KIND_KEYTYPE, !empty && result.record_kind == KIND_KEYLO, "key record order broken")

    // a stalled beat holds
    `APS_FHP_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result), "result changed while stalled")

endmodule

bind aps_frame_header_parser aps_fhp_checker u_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import aps_fhp_pkg::*;

    localparam int FRAME_STORE_DEPTH = 42;
    localparam int WATCHDOG_LIMIT    = 5000;
    localparam int SETTLE_CYCLES     = 20;
    localparam int RANDOM_BYTES      = 100;

    localparam logic       ST_OK        = 1'b0;
    localparam logic       ST_MALFORMED = 1'b1;

    typedef struct {
        int         len;
        logic [7:0] fc;
        logic [7:0] cmd_byte;
        logic [7:0] fill;
        logic [7:0] step;
        bit         pinned;
        out_t       rec;
    } frame_row_t;

    typedef struct {
        bit   on;
        out_t rec;
    } frame_pin_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    in_t  item;
    logic empty;
    logic pop;
    out_t result;

    // parser model state
    logic [7:0] frame_bytes [FRAME_STORE_DEPTH];
    logic [7:0] frame_len;
    out_t       decoded [$];

    out_t       expected_recs [$];
    frame_pin_t frame_pins [$];
    frame_row_t frame_plan [$];
    logic [7:0] frame_q [$];

    int errors;
    int bytes_sent;
    int stall_cycles;
    int send_idle;
    int recv_idle;

    aps_frame_header_parser uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] byte_at(input int unsigned idx);
        if (idx >= FRAME_STORE_DEPTH)
            return 8'h00;
        return frame_bytes[idx];
    endfunction

    function automatic logic [63:0] le_field(input int unsigned idx, input int unsigned n);
        logic [63:0] v;
        v = 64'd0;
        for (int unsigned i = 0; i < n; i++)
            v |= {56'd0, byte_at(idx + i)} << (8 * i);
        return v;
    endfunction

    function automatic void add_rec(input logic st, input logic [7:0] fc,
                                    input rec_kind_t kind, input logic [63:0] value);
        out_t r;
        r.status         = st;
        r.fr_type        = fc[1:0];
        r.dlv_mode       = fc[6:4];
        r.security_level = fc[4:2];
        r.ack_fmt        = fc[1];
        r.ext_header     = fc[0];
        r.record_kind    = kind;
        r.record_value   = value;
        r.last_record    = 1'b0;
        decoded.push_back(r);
    endfunction

    function automatic void decode_frame(input int unsigned len);
        logic [7:0]  fc;
        logic [7:0]  cmd;
        int unsigned at;
        out_t        r;
        decoded.delete();
        fc = byte_at(0);
        at = 1;
        if (len < MIN_LEN)
            add_rec(ST_MALFORMED, 8'h00, KIND_NONE, 64'd0);
        else if (fc[1:0] == FT_CMD)
        begin
            cmd = byte_at(at);
            at++;
            add_rec(ST_OK, fc, KIND_CMD, {56'd0, cmd});
            // secured frames carry five extra header bytes before the body
            if (fc[4:2] != 3'd0)
                at += SEC_HDR_BYTES;
            if (cmd == TRANSPORT_KEY_ID && len >= at + TK_BODY_LEN)
            begin
                add_rec(ST_OK, fc, KIND_KEYTYPE, {56'd0, byte_at(at)});
                add_rec(ST_OK, fc, KIND_KEYLO, le_field(at + 1, 8));
                add_rec(ST_OK, fc, KIND_KEYHI, le_field(at + 9, 8));
                add_rec(ST_OK, fc, KIND_KEYSEQ, {56'd0, byte_at(at + 17)});
                add_rec(ST_OK, fc, KIND_DSTEUI, le_field(at + 18, 8));
                add_rec(ST_OK, fc, KIND_SRCEUI, le_field(at + 26, 8));
            end
        end
        else if (fc[1:0] == FT_DATA)
        begin
            if (fc[6:4] == DM_GROUP)
            begin
                if (len < GROUP_MIN_LEN)
                    add_rec(ST_MALFORMED, fc, KIND_NONE, 64'd0);
                else
                begin
                    add_rec(ST_OK, fc, KIND_GROUP, le_field(1, 2));
                    add_rec(ST_OK, fc, KIND_CLUSTER, le_field(3, 2));
                    add_rec(ST_OK, fc, KIND_SRCEP, {56'd0, byte_at(5)});
                    add_rec(ST_OK, fc, KIND_COUNTER, {56'd0, byte_at(6)});
                end
            end
            else if (len < DIRECT_MIN_LEN)
                add_rec(ST_MALFORMED, fc, KIND_NONE, 64'd0);
            else
            begin
                add_rec(ST_OK, fc, KIND_DSTEP, {56'd0, byte_at(1)});
                add_rec(ST_OK, fc, KIND_CLUSTER, le_field(2, 2));
                add_rec(ST_OK, fc, KIND_PROFILE, le_field(4, 2));
                add_rec(ST_OK, fc, KIND_SRCEP, {56'd0, byte_at(6)});
                add_rec(ST_OK, fc, KIND_COUNTER, {56'd0, byte_at(7)});
            end
        end
        else
            add_rec(ST_MALFORMED, fc, KIND_NONE, 64'd0);
        r = decoded.pop_back();
        r.last_record = 1'b1;
        decoded.push_back(r);
    endfunction

    function automatic void take_byte(input in_t b);
        if (frame_len < FRAME_STORE_DEPTH)
            frame_bytes[frame_len] = b.data_byte;
        if (frame_len != 8'hFF)
            frame_len++;
        if (b.last_byte)
        begin
            decode_frame(frame_len);
            frame_len = 8'd0;
        end
    endfunction

    function automatic out_t malformed(input logic [1:0] ft, input logic [2:0] dm,
                                       input logic [2:0] sec, input logic ack,
                                       input logic ext);
        out_t r;
        r.status         = ST_MALFORMED;
        r.fr_type        = ft;
        r.dlv_mode       = dm;
        r.security_level = sec;
        r.ack_fmt        = ack;
        r.ext_header     = ext;
        r.record_kind    = KIND_NONE;
        r.record_value   = 64'd0;
        r.last_record    = 1'b1;
        return r;
    endfunction

    function automatic void plan_frame(input int len, input logic [7:0] fc,
                                       input logic [7:0] cmd_byte, input logic [7:0] fill,
                                       input logic [7:0] step, input bit pinned,
                                       input out_t rec);
        frame_row_t row;
        row.len      = len;
        row.fc       = fc;
        row.cmd_byte = cmd_byte;
        row.fill     = fill;
        row.step     = step;
        row.pinned   = pinned;
        row.rec      = rec;
        frame_plan.push_back(row);
    endfunction

    task automatic check_rec(input out_t want, input out_t got);
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
        if (got.fr_type !== want.fr_type)
        begin
            $error("fr_type: expected %0d, got %0d", want.fr_type, got.fr_type);
            errors++;
        end
        if (got.dlv_mode !== want.dlv_mode)
        begin
            $error("dlv_mode: expected %0d, got %0d",
                   want.dlv_mode, got.dlv_mode);
            errors++;
        end
        if (got.security_level !== want.security_level)
        begin
            $error("security_level: expected %0d, got %0d",
                   want.security_level, got.security_level);
            errors++;
        end
        if (got.ack_fmt !== want.ack_fmt)
        begin
            $error("ack_fmt: expected %0d, got %0d", want.ack_fmt, got.ack_fmt);
            errors++;
        end
        if (got.ext_header !== want.ext_header)
        begin
            $error("ext_header: expected %0d, got %0d", want.ext_header, got.ext_header);
            errors++;
        end
        if (got.record_kind !== want.record_kind)
        begin
            $error("record_kind: expected %0d, got %0d", want.record_kind, got.record_kind);
            errors++;
        end
        if (got.record_value !== want.record_value)
        begin
            $error("record_value: expected %h, got %h", want.record_value, got.record_value);
            errors++;
        end
        if (got.last_record !== want.last_record)
        begin
            $error("last_record: expected %0d, got %0d", want.last_record, got.last_record);
            errors++;
        end
    endtask

    // input side: model update on every accepted beat
    always @(posedge clk)
    begin
        frame_pin_t pin;
        if (rst_n && push && !full)
        begin
            take_byte(item);
            if (item.last_byte)
            begin
                pin = frame_pins.pop_front();
                if (pin.on)
                    expected_recs.push_back(pin.rec);
                else
                    foreach (decoded[i])
                        expected_recs.push_back(decoded[i]);
            end
        end
    end

    // output side
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_recs.size() == 0)
            begin
                $error("record beat with nothing expected: kind %0d value %h",
                       result.record_kind, result.record_value);
                errors++;
            end
            else
                check_rec(expected_recs.pop_front(), result);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else if (push || expected_recs.size() != 0)
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_beat(input in_t b);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= b;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic send_frame(input bit pinned, input out_t rec);
        frame_pin_t pin;
        in_t        b;
        pin.on  = pinned;
        pin.rec = rec;
        frame_pins.push_back(pin);
        for (int i = 0; i < frame_q.size(); i++)
        begin
            b.data_byte = frame_q[i];
            b.last_byte = (i == frame_q.size() - 1);
            send_beat(b);
        end
        bytes_sent += frame_q.size();
    endtask

    task automatic drain;
        push <= 1'b0;
        @(posedge clk);
        while (expected_recs.size() != 0)
            @(posedge clk);
    endtask

    task automatic build_random_frame;
        int         pick;
        int         len;
        int         need;
        logic [7:0] fc;
        logic [7:0] second;
        frame_q.delete();
        pick   = $urandom_range(99);
        fc     = 8'($urandom);
        second = 8'($urandom);
        if (pick < 22)
        begin
            // transport key, mostly long enough, now and then a few bytes short
            fc[1:0] = FT_CMD;
            second  = TRANSPORT_KEY_ID;
            need    = 2 + TK_BODY_LEN + ((fc[4:2] != 3'd0) ? int'(SEC_HDR_BYTES) : 0);
            if ($urandom_range(7) == 0)
                len = need - $urandom_range(1, 3);
            else
                len = need + $urandom_range(0, 2);
        end
        else if (pick < 44)
        begin
            fc[1:0] = FT_DATA;
            fc[6:4] = DM_GROUP;
            len = ($urandom_range(5) == 0) ? $urandom_range(2, 6) : $urandom_range(7, 10);
        end
        else if (pick < 66)
        begin
            fc[1:0] = FT_DATA;
            while (fc[6:4] == DM_GROUP)
                fc[6:4] = 3'($urandom);
            len = ($urandom_range(5) == 0) ? $urandom_range(2, 7) : $urandom_range(8, 11);
        end
        else if (pick < 80)
        begin
            fc[1:0] = FT_CMD;
            len = $urandom_range(2, 10);
        end
        else if (pick < 90)
        begin
            fc[1:0] = 2'($urandom_range(FT_ACK, FT_INTERPAN));
            len = $urandom_range(1, 8);
        end
        else
            len = ($urandom_range(9) == 0) ? $urandom_range(43, 70) : $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
                frame_q.push_back(fc);
            else if (i == 1)
                frame_q.push_back(second);
            else
                frame_q.push_back(8'($urandom));
        end
    endtask

    initial
    begin
        int phase_send [4];
        int phase_recv [4];
        int target;
        phase_send = '{0, 69, 0, 10};
        phase_recv = '{0, 0, 69, 10};
        errors       = 0;
        bytes_sent   = 0;
        stall_cycles = 0;
        send_idle    = 0;
        recv_idle    = 0;
        frame_len    = 8'd0;
        rst_n        = 1'b0;
        push        <= 1'b0;
        item        <= '0;

        // one-byte frames decode nothing; ack, interpan and short data frames are errors
        plan_frame(1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
                   malformed(FT_DATA, 3'd0, 3'd0, 1'b0, 1'b0));
        plan_frame(1, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1,
                   malformed(FT_DATA, 3'd0, 3'd0, 1'b0, 1'b0));
        plan_frame(2, 8'h02, 8'h00, 8'h00, 8'h00, 1'b1,
                   malformed(FT_ACK, 3'd0, 3'd0, 1'b1, 1'b0));
        plan_frame(2, 8'h03, 8'hFF, 8'h00, 8'h00, 1'b1,
                   malformed(FT_INTERPAN, 3'd0, 3'd0, 1'b1, 1'b1));
        plan_frame(5, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1,
                   malformed(FT_INTERPAN, 3'd7, 3'd7, 1'b1, 1'b1));
        plan_frame(6, 8'h20, 8'h12, 8'h34, 8'h01, 1'b1,
                   malformed(FT_DATA, DM_GROUP, 3'd0, 1'b0, 1'b0));
        plan_frame(7, 8'h20, 8'h11, 8'h11, 8'h11, 1'b0, '0);
        plan_frame(7, 8'h00, 8'h00, 8'hAA, 8'h00, 1'b1,
                   malformed(FT_DATA, 3'd0, 3'd0, 1'b0, 1'b0));
        plan_frame(8, 8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0, '0);
        plan_frame(8, 8'hF0, 8'h00, 8'h00, 8'h00, 1'b0, '0);
        plan_frame(2, 8'h01, TRANSPORT_KEY_ID, 8'h00, 8'h00, 1'b0, '0);
        plan_frame(3, 8'h01, 8'hFF, 8'h00, 8'h00, 1'b0, '0);
        plan_frame(40, 8'h05, TRANSPORT_KEY_ID, 8'h80, 8'h03, 1'b0, '0);
        plan_frame(41, 8'h05, TRANSPORT_KEY_ID, 8'h80, 8'h03, 1'b0, '0);
        // length count saturates: one byte past the top would wrap to zero
        plan_frame(256, 8'hFD, TRANSPORT_KEY_ID, 8'hFF, 8'h00, 1'b0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (frame_plan[r])
        begin
            frame_q.delete();
            for (int i = 0; i < frame_plan[r].len; i++)
            begin
                if (i == 0)
                    frame_q.push_back(frame_plan[r].fc);
                else if (i == 1)
                    frame_q.push_back(frame_plan[r].cmd_byte);
                else
                    frame_q.push_back(8'(frame_plan[r].fill + frame_plan[r].step * i));
            end
            send_frame(frame_plan[r].pinned, frame_plan[r].rec);
        end
        drain();

        bytes_sent = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = phase_send[ph];
            recv_idle = phase_recv[ph];
            target    = (RANDOM_BYTES * (ph + 1)) / 4;
            while (bytes_sent < target)
            begin
                build_random_frame();
                send_frame(1'b0, '0);
            end
            // hold off the sender until every record is out
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
